// ===== rtl/core/seht_pkg.sv =====
// Shared types and constants of the sorted epoch history table.
package seht_pkg;

	// Default number of records the table holds.
	localparam int CAPACITY_DEF = 512;

	// Width of the reported table length.
	localparam int LEN_W = 10;

	// Item kinds.
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_OVERWRITTEN = 3'd0;
	localparam logic [2:0] ST_INSERTED    = 3'd1;
	localparam logic [2:0] ST_DROPPED     = 3'd2;
	localparam logic [2:0] ST_HIT         = 3'd3;
	localparam logic [2:0] ST_MISS        = 3'd4;

	// One stored record.
	typedef struct packed {
		logic [63:0] epoch;
		logic [63:0] effective;
		logic [63:0] activating;
		logic [63:0] deactivating;
	} rec_t;

	// Input beat.
	typedef struct packed {
		logic        kind;
		logic [63:0] epoch;
		logic [63:0] effective;
		logic [63:0] activating;
		logic [63:0] deactivating;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [2:0]       status;
		logic [LEN_W-1:0] table_length;
		logic [63:0]      hit_epoch;
		logic [63:0]      hit_effective;
		logic [63:0]      hit_activating;
		logic [63:0]      hit_deactivating;
	} result_t;

	// Ring control from the head unit to the cell chain.
	typedef struct packed {
		logic shift;
		rec_t data;
	} ring_t;

endpackage

// ===== rtl/core/seht_cell.sv =====
// One table cell: holds a record and takes its neighbor's record on a shift.
module seht_cell (
	input  logic           clk,
	input  logic           shift,
	input  seht_pkg::rec_t d,
	output seht_pkg::rec_t q
);

	seht_pkg::rec_t rec_q;

	// Record register; the chain moves one slot per shift cycle.
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

// ===== rtl/core/seht_ctrl.sv =====
// Head unit: sequencing, compare and insert logic at the exit of the cell ring.
module seht_ctrl #(
	parameter int CAPACITY = seht_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  seht_pkg::item_t   item,
	input  seht_pkg::rec_t    head,
	output logic              busy,
	output logic              done,
	output seht_pkg::result_t result,
	output seht_pkg::ring_t   ring
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   off_q;
	logic            found_q;
	logic            ins_q;
	logic            ovw_q;
	logic            qhit_q;
	seht_pkg::item_t req_q;
	seht_pkg::rec_t  carry_q;
	seht_pkg::rec_t  hit_q;

	logic            accept;
	logic [63:0]     off64;
	logic            qhit;
	seht_pkg::rec_t  new_rec;
	logic            in_range;
	logic            at_tail;
	logic            match;
	logic            older;
	logic            last;
	logic            take_ovw;
	logic            take_ins;
	logic [CW-1:0]   count_nx;
	logic [CW+seht_pkg::LEN_W-1:0] len_ext;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Query offset from the newest epoch, checked against the fill level.
	assign off64 = head.epoch - item.epoch;
	assign qhit  = (count_q != '0) && (item.epoch <= head.epoch) && (off64 < 64'(count_q));

	assign new_rec = '{epoch: req_q.epoch, effective: req_q.effective,
		activating: req_q.activating, deactivating: req_q.deactivating};

	// Slot compare for the record leaving the ring.
	assign in_range = CW'(idx_q) < count_q;
	assign at_tail  = CW'(idx_q) == count_q;
	assign match    = head.epoch == req_q.epoch;
	assign older    = head.epoch < req_q.epoch;
	assign last     = idx_q == IW'(CAPACITY - 1);

	assign take_ovw = (req_q.kind == seht_pkg::KIND_UPDATE) && !found_q && in_range && match;
	assign take_ins = (req_q.kind == seht_pkg::KIND_UPDATE) && !found_q && !take_ovw &&
		((in_range && older) || at_tail);

	// Record pushed into the tail of the ring.
	always_comb begin
		ring.shift = (state_q == S_SCAN);
		ring.data  = head;
		if (take_ovw || take_ins) begin
			ring.data = new_rec;
		end else if (ins_q) begin
			ring.data = carry_q;
		end
	end

	// Sequencer and head registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			ins_q   <= 1'b0;
			ovw_q   <= 1'b0;
			qhit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
						ins_q   <= 1'b0;
						ovw_q   <= 1'b0;
						qhit_q  <= qhit;
					end
				end
				S_SCAN: begin
					if (take_ovw) begin
						found_q <= 1'b1;
						ovw_q   <= 1'b1;
					end
					if (take_ins) begin
						found_q <= 1'b1;
						ins_q   <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					count_q <= count_nx;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request, shifted-out carry and query capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= item;
			off_q <= off64[IW-1:0];
		end
		if (state_q == S_SCAN) begin
			if (take_ins || ins_q) begin
				carry_q <= head;
			end
			if (idx_q == off_q) begin
				hit_q <= head;
			end
		end
	end

	// Fill level after this item.
	assign count_nx = (ins_q && (count_q != CW'(CAPACITY))) ? count_q + 1'b1 : count_q;
	assign len_ext  = {{seht_pkg::LEN_W{1'b0}}, count_nx};

	// Result beat, shown for the single emit cycle.
	always_comb begin
		done = (state_q == S_EMIT);
		result = '0;
		result.table_length = len_ext[seht_pkg::LEN_W-1:0];
		if (req_q.kind == seht_pkg::KIND_UPDATE) begin
			if (ovw_q) begin
				result.status = seht_pkg::ST_OVERWRITTEN;
			end else if (ins_q) begin
				result.status = seht_pkg::ST_INSERTED;
			end else begin
				result.status = seht_pkg::ST_DROPPED;
			end
		end else if (qhit_q) begin
			result.status           = seht_pkg::ST_HIT;
			result.hit_epoch        = hit_q.epoch;
			result.hit_effective    = hit_q.effective;
			result.hit_activating   = hit_q.activating;
			result.hit_deactivating = hit_q.deactivating;
		end else begin
			result.status = seht_pkg::ST_MISS;
		end
	end

endmodule

// ===== rtl/core/sorted_epoch_history_table.sv =====
// The result strobe is raised in the emit state, after the scan state has rotated the ring once.
// The records sit in a ring of CAPACITY cells that rotates once per item past the head unit.
// A new item is taken only when the previous one is done; busy is high for the whole rotation.
// The result is on the ports for one cycle with done high and is not held.
// Reset clears the fill level to zero; record contents are not reset.
// Top level of the sorted epoch history table.
module sorted_epoch_history_table #(
	parameter int CAPACITY = seht_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  seht_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output seht_pkg::result_t result
);

	seht_pkg::rec_t  cell_q [CAPACITY];
	seht_pkg::ring_t ring;

	// Head unit at the exit of cell 0.
	seht_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.head   (cell_q[0]),
		.busy   (busy),
		.done   (done),
		.result (result),
		.ring   (ring)
	);

	// Cell chain: each cell takes its upper neighbor, the last takes the head unit output.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			seht_cell u_cell (
				.clk   (clk),
				.shift (ring.shift),
				.d     (ring.data),
				.q     (cell_q[i])
			);
		end else begin : g_body
			seht_cell u_cell (
				.clk   (clk),
				.shift (ring.shift),
				.d     (cell_q[i+1]),
				.q     (cell_q[i])
			);
		end
	end

endmodule
